>>> rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and helpers for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;
    localparam int QUEUE_DEPTH = 2;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    localparam logic [ATTR_W-1:0] DEF_ATTR_RESET = 8'd15;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR   = 8'd10;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_READ
    } t_op;

    // Bits of one classified queue entry for a given grid size
    function automatic int entry_w(input int cols, input int rows);
        return 2 + 1 + CHAR_W + ATTR_W + $clog2(cols) + $clog2(rows) + $clog2(cols * rows);
    endfunction

endpackage

>>> rtl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Input side: takes beats, saturates the cell position, works out the cell
// address, substitutes the default attribute and classifies the operation.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    localparam int ENTRY_W = tcw_pkg::entry_w(COLUMNS, ROWS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attribute,
    input  logic                          i_at_cursor,
    input  logic [tcw_pkg::COL_IN_W-1:0]  i_col,
    input  logic [tcw_pkg::ROW_IN_W-1:0]  i_row,
    input  logic                          i_q_full,
    input  logic                          i_clearing,
    output logic                          o_push,
    output logic [ENTRY_W-1:0]            o_entry
);
    import tcw_pkg::*;

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(COLUMNS * ROWS);

    typedef struct packed {
        t_op                op;
        logic               at_cursor;
        logic [CHAR_W-1:0]  character;
        logic [ATTR_W-1:0]  attribute;
        logic [CW-1:0]      col;
        logic [RW-1:0]      row;
        logic [AW-1:0]      addr;
    } t_entry;

    logic [ATTR_W-1:0] r_def_attr;
    logic [CW-1:0]     sat_col;
    logic [RW-1:0]     sat_row;
    t_entry            ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_attr <= DEF_ATTR_RESET;
        end else if (i_cfg_we) begin
            r_def_attr <= i_cfg_data;
        end
    end

    always_comb begin
        // clamp out-of-range positions to the last column / row
        sat_col = (int'(i_col) >= COLUMNS) ? CW'(COLUMNS - 1) : CW'(i_col);
        sat_row = (int'(i_row) >= ROWS) ? RW'(ROWS - 1) : RW'(i_row);

        if (i_action == ACT_READ) begin
            ent.op = OP_READ;
        end else if (i_character == NEWLINE_CHAR) begin
            ent.op = OP_NEWLINE;
        end else begin
            ent.op = OP_PUT;
        end
        ent.at_cursor = i_at_cursor & (i_action == ACT_PUT);
        ent.character = i_character;
        ent.attribute = (i_attribute == '0) ? r_def_attr : i_attribute;
        ent.col       = sat_col;
        ent.row       = sat_row;
        ent.addr      = AW'(sat_row) * AW'(COLUMNS) + AW'(sat_col);
    end

    assign o_ready = !i_q_full && !i_clearing;
    assign o_push  = i_valid && o_ready;
    assign o_entry = ENTRY_W'(ent);

endmodule

>>> rtl/tcw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = tcw_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import tcw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

endmodule

>>> rtl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Execution side: owns the cell memory and the cursor, carries out puts,
// newlines and reads, scrolls the screen and holds the result register.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    localparam int ENTRY_W = tcw_pkg::entry_w(COLUMNS, ROWS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  logic [ENTRY_W-1:0]            i_q_data,
    output logic                          o_pop,
    output logic                          o_clearing,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcw_pkg::COL_IN_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::ROW_IN_W-1:0]  o_cursor_row,
    output logic                          o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]    o_cell_attribute
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int MOVE  = CELLS - COLUMNS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);

    typedef struct packed {
        t_op                op;
        logic               at_cursor;
        logic [CHAR_W-1:0]  character;
        logic [ATTR_W-1:0]  attribute;
        logic [CW-1:0]      col;
        logic [RW-1:0]      row;
        logic [AW-1:0]      addr;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_COPY,
        S_WIPE
    } t_state;

    t_entry ent;

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic [AW-1:0]     mem_ra;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [AW-1:0]     r_cur_addr, n_cur_addr;

    logic                r_out_valid, n_out_valid;
    logic [COL_IN_W-1:0] r_out_col, n_out_col;
    logic [ROW_IN_W-1:0] r_out_row, n_out_row;
    logic                r_out_scrolled, n_out_scrolled;
    logic [CHAR_W-1:0]   r_out_char, n_out_char;
    logic [ATTR_W-1:0]   r_out_attr, n_out_attr;

    logic              out_free;
    logic [CW-1:0]     pos_col;
    logic [RW-1:0]     pos_row;
    logic [AW-1:0]     pos_addr;
    logic [CW-1:0]     nx_col;
    logic [RW:0]       nx_row;
    logic [AW:0]       nx_addr;
    logic              wrap;

    assign ent      = t_entry'(i_q_data);
    assign out_free = !r_out_valid || i_ready;

    // cursor step after a put or newline
    always_comb begin
        pos_col  = ent.at_cursor ? r_cur_col  : ent.col;
        pos_row  = ent.at_cursor ? r_cur_row  : ent.row;
        pos_addr = ent.at_cursor ? r_cur_addr : ent.addr;
        if (ent.op == OP_NEWLINE || pos_col == CW'(COLUMNS - 1)) begin
            nx_col  = '0;
            nx_row  = (RW + 1)'(pos_row) + 1'b1;
            nx_addr = (AW + 1)'(pos_addr) - (AW + 1)'(pos_col) + (AW + 1)'(COLUMNS);
        end else begin
            nx_col  = pos_col + 1'b1;
            nx_row  = (RW + 1)'(pos_row);
            nx_addr = (AW + 1)'(pos_addr) + 1'b1;
        end
        wrap = (nx_row == (RW + 1)'(ROWS));
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_cur_col      = r_cur_col;
        n_cur_row      = r_cur_row;
        n_cur_addr     = r_cur_addr;
        n_out_valid    = r_out_valid && !i_ready;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_scrolled = r_out_scrolled;
        n_out_char     = r_out_char;
        n_out_attr     = r_out_attr;
        o_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = r_cnt;
        mem_wd         = '0;
        mem_ra         = ent.addr;

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop = 1'b1;
                    case (ent.op)
                        OP_READ: begin
                            n_state = S_READ;
                        end
                        OP_PUT, OP_NEWLINE: begin
                            mem_we = (ent.op == OP_PUT);
                            mem_wa = pos_addr;
                            mem_wd = {ent.attribute, ent.character};
                            if (wrap) begin
                                n_cur_col  = '0;
                                n_cur_row  = RW'(ROWS - 1);
                                n_cur_addr = AW'(MOVE);
                                n_cnt      = '0;
                                n_state    = S_COPY;
                            end else begin
                                n_cur_col      = nx_col;
                                n_cur_row      = nx_row[RW-1:0];
                                n_cur_addr     = nx_addr[AW-1:0];
                                n_out_valid    = 1'b1;
                                n_out_col      = COL_IN_W'(nx_col);
                                n_out_row      = ROW_IN_W'(nx_row[RW-1:0]);
                                n_out_scrolled = 1'b0;
                                n_out_char     = '0;
                                n_out_attr     = '0;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid    = 1'b1;
                n_out_col      = COL_IN_W'(r_cur_col);
                n_out_row      = ROW_IN_W'(r_cur_row);
                n_out_scrolled = 1'b0;
                n_out_char     = r_rdata[CHAR_W-1:0];
                n_out_attr     = r_rdata[CELL_W-1:CHAR_W];
                n_state        = S_IDLE;
            end
            S_COPY: begin
                // read one row ahead, write the previous read one slot behind
                if (r_cnt != AW'(MOVE)) begin
                    mem_ra = r_cnt + AW'(COLUMNS);
                end
                mem_we = (r_cnt != '0);
                mem_wa = r_cnt - 1'b1;
                mem_wd = r_rdata;
                if (r_cnt == AW'(MOVE)) begin
                    n_state = S_WIPE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WIPE: begin
                mem_we = 1'b1;
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt          = '0;
                    n_state        = S_IDLE;
                    n_out_valid    = 1'b1;
                    n_out_col      = COL_IN_W'(r_cur_col);
                    n_out_row      = ROW_IN_W'(r_cur_row);
                    n_out_scrolled = 1'b1;
                    n_out_char     = '0;
                    n_out_attr     = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_cur_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_cur_addr  <= n_cur_addr;
            r_out_valid <= n_out_valid;
        end
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_scrolled <= n_out_scrolled;
        r_out_char     <= n_out_char;
        r_out_attr     <= n_out_attr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[mem_ra];
    end

    assign o_clearing       = (r_state == S_CLEAR);
    assign o_valid          = r_out_valid;
    assign o_cursor_col     = r_out_col;
    assign o_cursor_row     = r_out_row;
    assign o_scrolled       = r_out_scrolled;
    assign o_cell_char      = r_out_char;
    assign o_cell_attribute = r_out_attr;

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE) && (!r_out_valid || i_ready))
        else $error("entry taken while back busy or result pending");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_cur_col) < COLUMNS) && (int'(r_cur_row) < ROWS))
        else $error("cursor outside the grid");

    a_cursor_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur_addr) == int'(r_cur_row) * COLUMNS + int'(r_cur_col))
        else $error("cursor address out of step with column and row");

    a_scroll_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WIPE) && (r_cnt == AW'(CELLS - 1)) |=>
        o_valid && o_scrolled && (o_cursor_col == '0))
        else $error("scroll did not end in a scrolled result at column zero");

endmodule

>>> rtl/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: a COLUMNS x ROWS grid of character/attribute cells and a
// cursor. A put writes one cell (at the cursor or at col/row) and advances the
// cursor; a newline moves to the start of the next row; running off the last
// cell scrolls the grid up one row. A read returns one cell. Every beat gives
// one result. After reset the block zeroes the cell memory and takes no beat
// until that is done. Puts and newlines are carried out in the idle state;
// reads pass through a read state for the memory's registered read port; a put
// or newline that scrolls moves every row up and clears the last, one cell
// moved or cleared per cycle through the single memory write port. A two-entry
// queue lets up to two further beats be taken while the execution stage is busy.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_character,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attribute,
    input  logic                          i_at_cursor,
    input  logic [tcw_pkg::COL_IN_W-1:0]  i_col,
    input  logic [tcw_pkg::ROW_IN_W-1:0]  i_row,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tcw_pkg::COL_IN_W-1:0]  o_cursor_col,
    output logic [tcw_pkg::ROW_IN_W-1:0]  o_cursor_row,
    output logic                          o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]    o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]    o_cell_attribute
);
    import tcw_pkg::*;

    localparam int ENTRY_W = entry_w(COLUMNS, ROWS);

    logic               push;
    logic [ENTRY_W-1:0] push_entry;
    logic               q_full;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               pop;
    logic               clearing;

    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_character (i_character),
        .i_attribute (i_attribute),
        .i_at_cursor (i_at_cursor),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    tcw_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_data         (q_data),
        .o_pop            (pop),
        .o_clearing       (clearing),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_cursor_col     (o_cursor_col),
        .o_cursor_row     (o_cursor_row),
        .o_scrolled       (o_scrolled),
        .o_cell_char      (o_cell_char),
        .o_cell_attribute (o_cell_attribute)
    );

endmodule
